// ===== rtl/gdda_pkg.sv =====
// Shared types and constants of the grid DDA column raycaster.
// Used by the top level of the block; depends on nothing else.
package gdda_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAP_BITS   = 6;
    localparam int MAP_DEPTH  = 1 << (2 * MAP_BITS);
    localparam int WALK_LIMIT = 2 * (1 << MAP_BITS) + 4;
    localparam int DIV_W      = 42;
    localparam int HEIGHT_CAP = 1 << 20;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_POSITION_X    = 3'd2;
    localparam logic [2:0] REG_POSITION_Y    = 3'd3;
    localparam logic [2:0] REG_DIRECTION_X   = 3'd4;
    localparam logic [2:0] REG_DIRECTION_Y   = 3'd5;
    localparam logic [2:0] REG_PLANE_X       = 3'd6;
    localparam logic [2:0] REG_PLANE_Y       = 3'd7;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_CAM   = 15'b000000000000010,
        S_MRX   = 15'b000000000000100,
        S_MRY   = 15'b000000000001000,
        S_RYCAP = 15'b000000000010000,
        S_DX    = 15'b000000000100000,
        S_DY    = 15'b000000001000000,
        S_MSX   = 15'b000000010000000,
        S_MSY   = 15'b000000100000000,
        S_SYCAP = 15'b000001000000000,
        S_STEP  = 15'b000010000000000,
        S_CHECK = 15'b000100000000000,
        S_DIST  = 15'b001000000000000,
        S_HGT   = 15'b010000000000000,
        S_EMIT  = 15'b100000000000000
    } t_state;

endpackage

// ===== rtl/gdda_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the wall map; depends on nothing else.
module gdda_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gdda_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Shared by every division of the raycaster; no package dependencies.
module gdda_div #(
    parameter int WIDTH = 42
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_num,
    input  logic [WIDTH-1:0] i_den,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quot
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_trial;

    assign w_shift = {r_rem, r_quo[WIDTH-1]};
    assign w_trial = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_trial[WIDTH]) begin
                r_rem <= w_trial[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== rtl/grid_dda_column_raycaster.sv =====
// Top level of the grid DDA column raycaster.
// Depends on gdda_pkg, gdda_div (shared divider) and gdda_ram (wall map).
//
// A command is taken when start is high and busy is low. A write command
// stores one wall bit in the 64 x 64 map in the cycle it is taken and leaves
// busy low, so writes can stream one per cycle. A cast command raises busy
// and walks the ray for one screen column. Its result appears on the o_ ports
// for exactly one cycle, flagged by o_done; the receiver cannot stall it, so
// it must take the result in that cycle. A cast makes up to five passes
// through the shared 42-bit restoring divider (camera x, the two delta
// distances, the perpendicular distance and the wall height), with a step
// state and a check state for each map cell the ray crosses. A cast whose ray
// direction is zero along the axis of the hit side skips the distance and
// height divisions; one whose distance is zero skips the height division. The
// divider and the 18 x 35 multiplier are the units the sequencer reuses.
// The user must write the configuration registers through the APB-style port
// only while busy is low; the block itself does not enforce this. Reads
// return the stored value zero-extended.
module grid_dda_column_raycaster
    import gdda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [5:0]  i_cell_row,
    input  logic [5:0]  i_cell_col,
    input  logic        i_wall_bit,
    input  logic [11:0] i_screen_column,
    output logic        o_done,
    output logic [11:0] o_column_out,
    output logic [12:0] o_span_start,
    output logic [12:0] o_span_end,
    output logic        o_hit_side,
    output logic [5:0]  o_hit_cell_x,
    output logic [5:0]  o_hit_cell_y,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [12:0]        r_screen_width;
    logic [12:0]        r_screen_height;
    logic [21:0]        r_position_x;
    logic [21:0]        r_position_y;
    logic signed [17:0] r_direction_x;
    logic signed [17:0] r_direction_y;
    logic signed [17:0] r_plane_x;
    logic signed [17:0] r_plane_y;

    t_state r_state, n_state;
    logic   r_div_go, n_div_go;

    // Datapath registers of the cast in flight.
    logic [11:0]        r_column;
    logic signed [30:0] r_cam;
    logic signed [52:0] r_prod;
    logic signed [33:0] r_rx;
    logic signed [33:0] r_ry;
    logic [32:0]        r_dx;
    logic [32:0]        r_dy;
    logic [41:0]        r_sx;
    logic [41:0]        r_sy;
    logic [7:0]         r_mx;
    logic [7:0]         r_my;
    logic               r_side;
    logic [7:0]         r_steps;
    logic [41:0]        r_dist;
    logic [20:0]        r_lh;

    logic               r_done;
    logic [11:0]        r_column_out;
    logic [12:0]        r_span_start;
    logic [12:0]        r_span_end;
    logic               r_hit_side;
    logic [5:0]         r_hit_cell_x;
    logic [5:0]         r_hit_cell_y;

    logic               w_accept;
    logic               w_cfg_wr;
    logic [12:0]        w_width;
    logic signed [17:0] w_mul_a;
    logic signed [34:0] w_mul_b;
    logic signed [52:0] w_prod;
    logic [DIV_W-1:0]   w_div_num;
    logic [DIV_W-1:0]   w_div_den;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_quot;
    logic               w_xinf;
    logic               w_yinf;
    logic [33:0]        w_magx;
    logic [33:0]        w_magy;
    logic [16:0]        w_fracx;
    logic [16:0]        w_fracy;
    logic               w_stepx;
    logic [7:0]         w_nmx;
    logic [7:0]         w_nmy;
    logic [11:0]        w_raddr;
    logic               w_cell_wall;
    logic               w_outside;
    logic               w_wall;
    logic [7:0]         w_bnd;
    logic [21:0]        w_pos;
    logic               w_neg;
    logic [25:0]        w_num;
    logic [25:0]        w_magn;
    logic               w_ray_zero;
    logic [11:0]        w_half_h;
    logic [19:0]        w_half_l;
    logic [12:0]        w_start;
    logic [20:0]        w_end_sum;
    logic [12:0]        w_end;

    assign w_accept = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign busy     = (r_state != S_IDLE);

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= 13'd640;
            r_screen_height <= 13'd480;
            r_position_x    <= 22'd98304;
            r_position_y    <= 22'd98304;
            r_direction_x   <= -18'sd65536;
            r_direction_y   <= 18'sd0;
            r_plane_x       <= 18'sd0;
            r_plane_y       <= 18'sd43253;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_SCREEN_WIDTH:  r_screen_width  <= pwdata[12:0];
                REG_SCREEN_HEIGHT: r_screen_height <= pwdata[12:0];
                REG_POSITION_X:    r_position_x    <= pwdata[21:0];
                REG_POSITION_Y:    r_position_y    <= pwdata[21:0];
                REG_DIRECTION_X:   r_direction_x   <= $signed(pwdata[17:0]);
                REG_DIRECTION_Y:   r_direction_y   <= $signed(pwdata[17:0]);
                REG_PLANE_X:       r_plane_x       <= $signed(pwdata[17:0]);
                REG_PLANE_Y:       r_plane_y       <= $signed(pwdata[17:0]);
                default:           r_plane_y       <= r_plane_y;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_SCREEN_WIDTH:  prdata = {19'd0, r_screen_width};
            REG_SCREEN_HEIGHT: prdata = {19'd0, r_screen_height};
            REG_POSITION_X:    prdata = {10'd0, r_position_x};
            REG_POSITION_Y:    prdata = {10'd0, r_position_y};
            REG_DIRECTION_X:   prdata = {14'd0, r_direction_x};
            REG_DIRECTION_Y:   prdata = {14'd0, r_direction_y};
            REG_PLANE_X:       prdata = {14'd0, r_plane_x};
            REG_PLANE_Y:       prdata = {14'd0, r_plane_y};
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Wall map. A write command goes straight in; the walk reads the cell
    // it is about to enter, and the registered data is checked in the next cycle.
    // ---------------------------------------------------------------
    assign w_stepx = !w_xinf && (w_yinf || (r_sx < r_sy));
    assign w_nmx   = r_mx + (r_rx[33] ? 8'hFF : 8'h01);
    assign w_nmy   = r_my + (r_ry[33] ? 8'hFF : 8'h01);
    assign w_raddr = w_stepx ? {r_my[5:0], w_nmx[5:0]} : {w_nmy[5:0], r_mx[5:0]};

    gdda_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_command == CMD_WRITE)),
        .i_waddr ({i_cell_row, i_cell_col}),
        .i_wdata (i_wall_bit),
        .i_raddr (w_raddr),
        .o_rdata (w_cell_wall)
    );

    // Cells outside the map read as walls.
    assign w_outside = (r_mx[7:6] != 2'b00) || (r_my[7:6] != 2'b00);
    assign w_wall    = w_outside || w_cell_wall;

    // ---------------------------------------------------------------
    // Shared multiplier: operands picked by the sequencer, product registered.
    // ---------------------------------------------------------------
    assign w_xinf  = (r_rx == 34'sd0);
    assign w_yinf  = (r_ry == 34'sd0);
    assign w_magx  = r_rx[33] ? 34'(-r_rx) : 34'(r_rx);
    assign w_magy  = r_ry[33] ? 34'(-r_ry) : 34'(r_ry);
    assign w_fracx = r_rx[33] ? {1'b0, r_position_x[15:0]}
                              : 17'h10000 - {1'b0, r_position_x[15:0]};
    assign w_fracy = r_ry[33] ? {1'b0, r_position_y[15:0]}
                              : 17'h10000 - {1'b0, r_position_y[15:0]};

    always_comb begin
        w_mul_a = r_plane_x;
        w_mul_b = {{4{r_cam[30]}}, r_cam};
        case (r_state)
            S_MRY: begin
                w_mul_a = r_plane_y;
            end
            S_MSX: begin
                w_mul_a = $signed({1'b0, w_fracx});
                w_mul_b = $signed({2'b00, r_dx});
            end
            S_MSY: begin
                w_mul_a = $signed({1'b0, w_fracy});
                w_mul_b = $signed({2'b00, r_dy});
            end
            default: begin
                w_mul_a = r_plane_x;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // ---------------------------------------------------------------
    // Shared divider operands.
    // ---------------------------------------------------------------
    assign w_width    = (r_screen_width == 13'd0) ? 13'd1 : r_screen_width;
    assign w_bnd      = r_side ? r_my : r_mx;
    assign w_pos      = r_side ? r_position_y : r_position_x;
    assign w_neg      = r_side ? r_ry[33] : r_rx[33];
    assign w_ray_zero = r_side ? w_yinf : w_xinf;
    // Signed offset from the viewer to the near boundary of the hit cell.
    assign w_num  = {{2{w_bnd[7]}}, w_bnd, 16'd0} - {4'd0, w_pos}
                  + (w_neg ? 26'h0010000 : 26'h0000000);
    assign w_magn = w_num[25] ? 26'(-w_num) : w_num;

    always_comb begin
        w_div_num = {13'd0, r_column, 17'd0};
        w_div_den = {29'd0, w_width};
        case (r_state)
            S_DX: begin
                w_div_num = DIV_W'(64'd1 << (2 * FRAC_BITS));
                w_div_den = {8'd0, w_magx};
            end
            S_DY: begin
                w_div_num = DIV_W'(64'd1 << (2 * FRAC_BITS));
                w_div_den = {8'd0, w_magy};
            end
            S_DIST: begin
                w_div_num = {w_magn, 16'd0};
                w_div_den = r_side ? {8'd0, w_magy} : {8'd0, w_magx};
            end
            S_HGT: begin
                w_div_num = {13'd0, r_screen_height, 16'd0};
                w_div_den = r_dist;
            end
            default: begin
                w_div_den = {29'd0, w_width};
            end
        endcase
    end

    gdda_div #(
        .WIDTH (DIV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // ---------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_div_go = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_command == CMD_CAST)) begin
                    n_state  = S_CAM;
                    n_div_go = 1'b1;
                end
            end
            S_CAM: begin
                if (w_div_done) begin
                    n_state = S_MRX;
                end
            end
            S_MRX:   n_state = S_MRY;
            S_MRY:   n_state = S_RYCAP;
            S_RYCAP: begin
                n_state  = S_DX;
                n_div_go = 1'b1;
            end
            S_DX: begin
                if (w_div_done) begin
                    n_state  = S_DY;
                    n_div_go = 1'b1;
                end
            end
            S_DY: begin
                if (w_div_done) begin
                    n_state = S_MSX;
                end
            end
            S_MSX:   n_state = S_MSY;
            S_MSY:   n_state = S_SYCAP;
            S_SYCAP: n_state = S_STEP;
            S_STEP:  n_state = S_CHECK;
            S_CHECK: begin
                if (w_wall || (r_steps == 8'(WALK_LIMIT))) begin
                    if (w_ray_zero) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state  = S_DIST;
                        n_div_go = 1'b1;
                    end
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DIST: begin
                if (w_div_done) begin
                    if (w_quot == '0) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state  = S_HGT;
                        n_div_go = 1'b1;
                    end
                end
            end
            S_HGT: begin
                if (w_div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_div_go <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= n_div_go;
            r_done   <= (r_state == S_EMIT);
        end
    end

    // Datapath updates, keyed on the state.
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (r_state)
            S_IDLE: begin
                r_column <= i_screen_column;
                r_mx     <= {2'b00, r_position_x[21:16]};
                r_my     <= {2'b00, r_position_y[21:16]};
                r_steps  <= '0;
                r_side   <= 1'b0;
            end
            S_CAM: begin
                r_cam <= $signed({1'b0, w_quot[29:0]}) - 31'sd65536;
            end
            S_MRY: begin
                r_rx <= 34'(r_direction_x) + $signed(r_prod[49:16]);
            end
            S_RYCAP: begin
                r_ry <= 34'(r_direction_y) + $signed(r_prod[49:16]);
            end
            S_DX: begin
                r_dx <= w_xinf ? 33'd0 : w_quot[32:0];
            end
            S_DY: begin
                r_dy <= w_yinf ? 33'd0 : w_quot[32:0];
            end
            S_MSY: begin
                r_sx <= {8'd0, r_prod[49:16]};
            end
            S_SYCAP: begin
                r_sy <= {8'd0, r_prod[49:16]};
            end
            S_STEP: begin
                r_steps <= r_steps + 8'd1;
                if (w_stepx) begin
                    r_sx   <= r_sx + {9'd0, r_dx};
                    r_mx   <= w_nmx;
                    r_side <= 1'b0;
                end else begin
                    r_sy   <= r_sy + {9'd0, r_dy};
                    r_my   <= w_nmy;
                    r_side <= 1'b1;
                end
            end
            S_CHECK: begin
                r_lh <= '0;
            end
            S_DIST: begin
                r_dist <= w_quot;
                r_lh   <= 21'(HEIGHT_CAP);
            end
            S_HGT: begin
                r_lh <= (w_quot > DIV_W'(HEIGHT_CAP)) ? 21'(HEIGHT_CAP) : w_quot[20:0];
            end
            default: begin
                r_steps <= r_steps;
            end
        endcase
    end

    // Span: centred on the middle row, clamped to the screen.
    assign w_half_h  = r_screen_height[12:1];
    assign w_half_l  = r_lh[20:1];
    assign w_start   = (w_half_l > {8'd0, w_half_h})
                     ? 13'd0 : 13'({8'd0, w_half_h} - w_half_l);
    assign w_end_sum = {1'b0, w_half_l} + {9'd0, w_half_h};
    assign w_end     = (w_end_sum > {8'd0, r_screen_height})
                     ? r_screen_height : w_end_sum[12:0];

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT) begin
            r_column_out <= r_column;
            r_span_start <= w_start;
            r_span_end   <= w_end;
            r_hit_side   <= r_side;
            r_hit_cell_x <= r_mx[5:0];
            r_hit_cell_y <= r_my[5:0];
        end
    end

    assign o_done       = r_done;
    assign o_column_out = r_column_out;
    assign o_span_start = r_span_start;
    assign o_span_end   = r_span_end;
    assign o_hit_side   = r_hit_side;
    assign o_hit_cell_x = r_hit_cell_x;
    assign o_hit_cell_y = r_hit_cell_y;

`ifndef SYNTHESIS
    // A result only follows the output state and never while a cast is running.
    a_done_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state == S_EMIT) && !busy))
        else $error("result strobe without a finished cast");

    // A cast command always occupies the block in the next cycle.
    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_CAST)) |=> busy)
        else $error("cast command did not start the sequencer");

    // A map write never occupies the block.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_WRITE)) |=> !busy)
        else $error("map write made the block busy");

    // The walk never runs past its step limit.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_steps < 8'(WALK_LIMIT)))
        else $error("ray walk exceeded its step limit");
`endif

endmodule
